/* hdl/rbsi_pkg.sv */
// ----------------------------------------------------------------------------
// rbsi_pkg: shared types and constants for the ray/box slab test
// Distance width, saturation limits and register indexes.
// ----------------------------------------------------------------------------
package rbsi_pkg;

    localparam int T_WIDTH   = 48;
    localparam int CFG_IDX_W = 3;

    localparam logic signed [T_WIDTH-1:0] T_POS = {1'b0, {(T_WIDTH-1){1'b1}}};
    localparam logic signed [T_WIDTH-1:0] T_NEG = {1'b1, {(T_WIDTH-1){1'b0}}};

    localparam logic [CFG_IDX_W-1:0] REG_MIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_Z = 3'd5;

    // per-axis flags that ride alongside the divider pipe
    typedef struct packed {
        logic       vld;
        logic [2:0] dz;     // direction component is zero
        logic [2:0] below;  // origin below box min
        logic [2:0] above;  // origin above box max
    } t_side;

endpackage

/* hdl/rbsi_div.sv */
// ----------------------------------------------------------------------------
// rbsi_div: pipelined fixed-point divider
// Signed num/den, one quotient bit per stage, truncated toward zero,
// saturated to T_WIDTH bits. Registered input, bit stages, registered output.
// ----------------------------------------------------------------------------
module rbsi_div
    import rbsi_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          i_clk,
    input  logic signed [COORD_WIDTH:0]   i_num,
    input  logic signed [COORD_WIDTH-1:0] i_den,
    output logic signed [T_WIDTH-1:0]     o_quot
);

    localparam int DW = COORD_WIDTH;
    localparam int QW = COORD_WIDTH + 1 + FRAC_BITS;
    localparam int EW = QW + T_WIDTH;

    logic [DW:0]   r_rem [0:QW];
    logic [QW-1:0] r_nq  [0:QW];
    logic [DW-1:0] r_den [0:QW];
    logic          r_neg [0:QW];
    logic signed [T_WIDTH-1:0] r_quot;

    logic [COORD_WIDTH:0] n_nmag;
    logic [DW-1:0]        n_dmag;

    always_comb begin
        n_nmag = i_num[COORD_WIDTH] ? (COORD_WIDTH+1)'(-i_num) : i_num;
        n_dmag = i_den[DW-1] ? DW'(-i_den) : i_den;
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= '0;
        r_nq[0]  <= {n_nmag, {FRAC_BITS{1'b0}}};
        r_den[0] <= n_dmag;
        r_neg[0] <= i_num[COORD_WIDTH] ^ i_den[DW-1];
    end

    for (genvar s = 1; s <= QW; s++) begin : g_stage
        logic [DW:0] trial;
        logic        ge;
        always_comb begin
            trial = {r_rem[s-1][DW-1:0], r_nq[s-1][QW-1]};
            ge    = trial >= {1'b0, r_den[s-1]};
        end
        always_ff @(posedge i_clk) begin
            r_rem[s] <= ge ? trial - {1'b0, r_den[s-1]} : trial;
            r_nq[s]  <= {r_nq[s-1][QW-2:0], ge};
            r_den[s] <= r_den[s-1];
            r_neg[s] <= r_neg[s-1];
        end
    end

    logic [EW-1:0] qx;
    always_comb qx = EW'(r_nq[QW]);

    always_ff @(posedge i_clk) begin
        if (r_neg[QW]) begin
            if (qx > EW'(T_POS) + EW'(1)) r_quot <= T_NEG;
            else                          r_quot <= -T_WIDTH'(qx);
        end else begin
            if (qx > EW'(T_POS)) r_quot <= T_POS;
            else                 r_quot <= T_WIDTH'(qx);
        end
    end

    assign o_quot = r_quot;

endmodule

/* hdl/ray_box_slab_intersect.sv */
// ----------------------------------------------------------------------------
// ray_box_slab_intersect: ray versus axis-aligned box slab test
// Streams one ray per clock through six pipelined dividers.
// ----------------------------------------------------------------------------
// Accepts a ray on every clock that start is high (busy stays low). The result
// (hit, t_near, t_far) shows with a one-cycle o_done strobe. Throughput is one
// transaction per clock. The pipeline is one input stage, the bit-per-stage
// dividers, then four stages for the compare and reduce. The receiver cannot
// stall, so o_done results must be captured when they show.
// Box corners are written through i_cfg_*; write them only while idle.
module ray_box_slab_intersect
    import rbsi_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [COORD_WIDTH-1:0]        i_cfg_wdata,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] i_ray_origin_x,
    input  logic signed [COORD_WIDTH-1:0] i_ray_origin_y,
    input  logic signed [COORD_WIDTH-1:0] i_ray_origin_z,
    input  logic signed [COORD_WIDTH-1:0] i_ray_dir_x,
    input  logic signed [COORD_WIDTH-1:0] i_ray_dir_y,
    input  logic signed [COORD_WIDTH-1:0] i_ray_dir_z,
    output logic                          o_done,
    output logic                          o_hit,
    output logic signed [T_WIDTH-1:0]     o_t_near,
    output logic signed [T_WIDTH-1:0]     o_t_far
);

    localparam int DIV_LAT = COORD_WIDTH + FRAC_BITS + 3;
    localparam logic [COORD_WIDTH-1:0] CFG_POS = COORD_WIDTH'(64'd999 << FRAC_BITS);
    localparam logic [COORD_WIDTH-1:0] CFG_NEG = COORD_WIDTH'(-CFG_POS);

    // box corner registers, [0..2] = x,y,z
    logic signed [COORD_WIDTH-1:0] r_bmin [0:2];
    logic signed [COORD_WIDTH-1:0] r_bmax [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_bmin[a] <= CFG_POS;
                r_bmax[a] <= CFG_NEG;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MIN_X: r_bmin[0] <= i_cfg_wdata;
                REG_MIN_Y: r_bmin[1] <= i_cfg_wdata;
                REG_MIN_Z: r_bmin[2] <= i_cfg_wdata;
                REG_MAX_X: r_bmax[0] <= i_cfg_wdata;
                REG_MAX_Y: r_bmax[1] <= i_cfg_wdata;
                REG_MAX_Z: r_bmax[2] <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    logic signed [COORD_WIDTH-1:0] w_org [0:2];
    logic signed [COORD_WIDTH-1:0] w_dir [0:2];
    assign w_org[0] = i_ray_origin_x;
    assign w_org[1] = i_ray_origin_y;
    assign w_org[2] = i_ray_origin_z;
    assign w_dir[0] = i_ray_dir_x;
    assign w_dir[1] = i_ray_dir_y;
    assign w_dir[2] = i_ray_dir_z;

    // stage 1: slab numerators (bound - origin), one bit wider
    logic signed [COORD_WIDTH:0]   r_nlo [0:2];
    logic signed [COORD_WIDTH:0]   r_nhi [0:2];
    logic signed [COORD_WIDTH-1:0] r_den [0:2];
    logic                          r_v1;

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            r_nlo[a] <= (COORD_WIDTH+1)'(r_bmin[a]) - (COORD_WIDTH+1)'(w_org[a]);
            r_nhi[a] <= (COORD_WIDTH+1)'(r_bmax[a]) - (COORD_WIDTH+1)'(w_org[a]);
            r_den[a] <= w_dir[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else          r_v1 <= start;
    end

    // flags travel beside the dividers
    t_side n_side;
    t_side r_side [0:DIV_LAT-1];

    always_comb begin
        n_side.vld = r_v1;
        for (int a = 0; a < 3; a++) begin
            n_side.dz[a]    = (r_den[a] == '0);
            n_side.below[a] = !r_nlo[a][COORD_WIDTH] && (r_nlo[a] != '0);
            n_side.above[a] = r_nhi[a][COORD_WIDTH];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_LAT; k++) r_side[k] <= '0;
        end else begin
            r_side[0] <= n_side;
            for (int k = 1; k < DIV_LAT; k++) r_side[k] <= r_side[k-1];
        end
    end

    logic signed [T_WIDTH-1:0] w_qa [0:2];
    logic signed [T_WIDTH-1:0] w_qb [0:2];

    for (genvar a = 0; a < 3; a++) begin : g_axis
        rbsi_div #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div_lo (
            .i_clk (i_clk),
            .i_num (r_nlo[a]),
            .i_den (r_den[a]),
            .o_quot(w_qa[a])
        );
        rbsi_div #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div_hi (
            .i_clk (i_clk),
            .i_num (r_nhi[a]),
            .i_den (r_den[a]),
            .o_quot(w_qb[a])
        );
    end

    // M1: per-axis entry/exit, zero-direction rule
    t_side                     w_sd;
    logic signed [T_WIDTH-1:0] r_lo [0:2];
    logic signed [T_WIDTH-1:0] r_hi [0:2];
    logic                      r_ok1, r_v2;

    assign w_sd = r_side[DIV_LAT-1];

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            if (w_sd.dz[a]) begin
                r_lo[a] <= w_sd.below[a] ? T_POS : T_NEG;
                r_hi[a] <= w_sd.above[a] ? T_NEG : T_POS;
            end else if (w_qa[a] < w_qb[a]) begin
                r_lo[a] <= w_qa[a];
                r_hi[a] <= w_qb[a];
            end else begin
                r_lo[a] <= w_qb[a];
                r_hi[a] <= w_qa[a];
            end
        end
        r_ok1 <= !(|(w_sd.dz & (w_sd.below | w_sd.above)));
    end

    // M2: reduce x and y, carry z
    logic signed [T_WIDTH-1:0] r_tn2, r_tf2, r_lz, r_hz;
    logic                      r_ok2, r_v3;

    always_ff @(posedge i_clk) begin
        r_tn2 <= (r_lo[0] > r_lo[1]) ? r_lo[0] : r_lo[1];
        r_tf2 <= (r_hi[0] < r_hi[1]) ? r_hi[0] : r_hi[1];
        r_lz  <= r_lo[2];
        r_hz  <= r_hi[2];
        r_ok2 <= r_ok1;
    end

    // M3: fold in z
    logic signed [T_WIDTH-1:0] r_tn3, r_tf3;
    logic                      r_ok3, r_v4;

    always_ff @(posedge i_clk) begin
        r_tn3 <= (r_tn2 > r_lz) ? r_tn2 : r_lz;
        r_tf3 <= (r_tf2 < r_hz) ? r_tf2 : r_hz;
        r_ok3 <= r_ok2;
    end

    // M4: hit decision and output registers
    logic signed [T_WIDTH-1:0] r_tn4, r_tf4;
    logic                      r_hit;

    always_ff @(posedge i_clk) begin
        r_tn4 <= r_tn3;
        r_tf4 <= r_tf3;
        r_hit <= r_ok3 && !r_tf3[T_WIDTH-1] && !(r_tn3 > r_tf3);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            o_done <= 1'b0;
        end else begin
            r_v2 <= w_sd.vld;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            o_done <= r_v4;
        end
    end

    assign o_hit    = r_hit;
    assign o_t_near = r_tn4;
    assign o_t_far  = r_tf4;

endmodule
